// ----- hdl/mips_system_control_coprocessor_macros.svh -----
// Assertion macros for the coprocessor top-level design file.
`ifndef MIPS_SYSTEM_CONTROL_COPROCESSOR_MACROS_SVH
`define MIPS_SYSTEM_CONTROL_COPROCESSOR_MACROS_SVH
`ifndef ASSERT_OFF
// Checks that a condition implies another at the same edge.
`define MSCC_ASSERT_IMPLY(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("same-cycle implication violated");
// Checks that a condition implies another at the next edge.
`define MSCC_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("next-cycle implication violated");
`else
`define MSCC_ASSERT_IMPLY(label, clk, rst_n, a, b)
`define MSCC_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

// ----- hdl/mscc_pkg.sv -----
// Shared types, constants and decode functions of the system control coprocessor.
`default_nettype none
package mscc_pkg;
	localparam int TLB_ENTRIES = 32;
	localparam int TLB_IDX_W = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
	localparam logic [6:0] TLB_COUNT = 7'(TLB_ENTRIES);
	localparam logic [5:0] RANDOM_TOP = 6'(TLB_ENTRIES - 1);

	// Operation codes.
	localparam logic [3:0] OP_MFC0 = 4'd0;
	localparam logic [3:0] OP_DMFC0 = 4'd1;
	localparam logic [3:0] OP_MTC0 = 4'd2;
	localparam logic [3:0] OP_DMTC0 = 4'd3;
	localparam logic [3:0] OP_TLBR = 4'd4;
	localparam logic [3:0] OP_TLBWI = 4'd5;
	localparam logic [3:0] OP_TLBWR = 4'd6;
	localparam logic [3:0] OP_ERET = 4'd7;
	localparam logic [3:0] OP_TICK = 4'd8;

	// Result status codes.
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_BAD_REG = 2'd1;
	localparam logic [1:0] ST_BAD_TLB = 2'd2;

	// Register numbers with their own storage.
	localparam logic [4:0] REG_INDEX = 5'd0;
	localparam logic [4:0] REG_RANDOM = 5'd1;
	localparam logic [4:0] REG_PAGEMASK = 5'd5;
	localparam logic [4:0] REG_WIRED = 5'd6;

	// Wide register slots.
	localparam logic [2:0] W_LO0 = 3'd0;
	localparam logic [2:0] W_LO1 = 3'd1;
	localparam logic [2:0] W_CTX = 3'd2;
	localparam logic [2:0] W_BAD = 3'd3;
	localparam logic [2:0] W_HI = 3'd4;
	localparam logic [2:0] W_EPC = 3'd5;
	localparam logic [2:0] W_XCTX = 3'd6;
	localparam logic [2:0] W_ERR = 3'd7;

	// Narrow register slots.
	localparam int NARROW_N = 13;
	localparam logic [3:0] N_COUNT = 4'd0;
	localparam logic [3:0] N_CMP = 4'd1;
	localparam logic [3:0] N_SR = 4'd2;
	localparam logic [3:0] N_CAUSE = 4'd3;

	localparam int BIT_FR = 26;
	localparam int BIT_IP7 = 15;
	localparam int BIT_ERL = 2;
	localparam int BIT_EXL = 1;
	localparam logic [31:0] SOFT_IP = 32'h0000_0300;
	localparam logic [31:0] PM_MASK = 32'h01ff_e000;

	typedef struct packed {
		logic hit;
		logic [2:0] idx;
	} wslot_t;

	typedef struct packed {
		logic hit;
		logic [3:0] idx;
	} nslot_t;

	typedef struct packed {
		logic [31:0] page_mask;
		logic [63:0] entry_hi;
		logic [63:0] lo_even;
		logic [63:0] lo_odd;
	} tlb_entry_t;

	typedef struct packed {
		logic en;
		logic [TLB_IDX_W-1:0] addr;
		tlb_entry_t data;
	} tlb_wr_t;

	function automatic logic [63:0] sext32(input logic [31:0] v);
		return {{32{v[31]}}, v};
	endfunction

	function automatic wslot_t wide_slot(input logic [4:0] r);
		wslot_t s;
		s = '{hit: 1'b1, idx: W_LO0};
		unique case (r)
			5'd2: s.idx = W_LO0;
			5'd3: s.idx = W_LO1;
			5'd4: s.idx = W_CTX;
			5'd8: s.idx = W_BAD;
			5'd10: s.idx = W_HI;
			5'd14: s.idx = W_EPC;
			5'd20: s.idx = W_XCTX;
			5'd30: s.idx = W_ERR;
			default: s.hit = 1'b0;
		endcase
		return s;
	endfunction

	function automatic nslot_t narrow_slot(input logic [4:0] r);
		nslot_t s;
		s = '{hit: 1'b1, idx: N_COUNT};
		unique case (r)
			5'd9: s.idx = N_COUNT;
			5'd11: s.idx = N_CMP;
			5'd12: s.idx = N_SR;
			5'd13: s.idx = N_CAUSE;
			5'd15: s.idx = 4'd4;
			5'd16: s.idx = 4'd5;
			5'd17: s.idx = 4'd6;
			5'd18: s.idx = 4'd7;
			5'd19: s.idx = 4'd8;
			5'd26: s.idx = 4'd9;
			5'd27: s.idx = 4'd10;
			5'd28: s.idx = 4'd11;
			5'd29: s.idx = 4'd12;
			default: s.hit = 1'b0;
		endcase
		return s;
	endfunction
endpackage
`default_nettype wire

// ----- hdl/mscc_tlb.sv -----
// TLB entry store: one write port and one asynchronous read port.
`default_nettype none
module mscc_tlb (
	input wire logic clk,
	input wire mscc_pkg::tlb_wr_t wr,
	input wire logic [mscc_pkg::TLB_IDX_W-1:0] rd_addr,
	output mscc_pkg::tlb_entry_t rd_entry
);
	mscc_pkg::tlb_entry_t entry_q [mscc_pkg::TLB_ENTRIES];

	// Entries are written by the indexed and random write operations.
	always_ff @(posedge clk) begin
		if (wr.en) begin
			entry_q[wr.addr] <= wr.data;
		end
	end

	// Read at the Index register for the TLB read operation.
	assign rd_entry = entry_q[rd_addr];
endmodule
`default_nettype wire

// ----- hdl/mips_system_control_coprocessor.sv -----
// Items pass through the input register and then the result register.
// Throughput: one item per cycle while out_stall is low; the decode and register
// update of each item are combinational between the two registers.
// Reset clears control state and all coprocessor registers but Random, which resets to the
// top TLB entry. TLB entries hold unknown contents until written.
`default_nettype none
`include "mips_system_control_coprocessor_macros.svh"
module mips_system_control_coprocessor (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [3:0] opcode,
	input wire logic [4:0] reg_number,
	input wire logic [63:0] write_data,
	output logic out_valid,
	input wire logic out_stall,
	output logic [63:0] read_data,
	output logic jump_taken,
	output logic [63:0] jump_target,
	output logic fr_changed,
	output logic fr_mode,
	output logic timer_irq,
	output logic [1:0] status
);
	logic valid_s1;
	logic [3:0] opcode_s1;
	logic [4:0] reg_number_s1;
	logic [63:0] write_data_s1;
	logic advance;

	logic [5:0] index_q, random_q, wired_q;
	logic [5:0] index_d, random_d, wired_d;
	logic [31:0] page_mask_q, page_mask_d;
	logic [63:0] wide_q [8];
	logic [63:0] wide_d [8];
	logic [31:0] narrow_q [mscc_pkg::NARROW_N];
	logic [31:0] narrow_d [mscc_pkg::NARROW_N];
	logic phase_q, phase_d;

	logic [63:0] rd_c, tgt_c;
	logic jump_c, frch_c;
	logic [1:0] st_c;
	logic [31:0] w32;
	logic [31:0] count_inc;
	logic [5:0] tlb_idx;
	mscc_pkg::wslot_t ws;
	mscc_pkg::nslot_t ns;
	mscc_pkg::tlb_wr_t tlb_wr;
	mscc_pkg::tlb_entry_t tlb_rd;

	// Input stage moves when the result register is free or being drained.
	assign advance = valid_s1 && (!out_valid || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			opcode_s1 <= opcode;
			reg_number_s1 <= reg_number;
			write_data_s1 <= write_data;
		end
	end

	mscc_tlb u_tlb (
		.clk(clk),
		.wr(tlb_wr),
		.rd_addr(index_q[mscc_pkg::TLB_IDX_W-1:0]),
		.rd_entry(tlb_rd)
	);

	assign w32 = write_data_s1[31:0];
	assign ws = mscc_pkg::wide_slot(reg_number_s1);
	assign ns = mscc_pkg::narrow_slot(reg_number_s1);
	assign count_inc = narrow_q[mscc_pkg::N_COUNT] + 32'd1;
	assign tlb_idx = (opcode_s1 == mscc_pkg::OP_TLBWR) ? random_q : index_q;

	// Decode one operation and work out the next register state.
	always_comb begin
		index_d = index_q;
		random_d = random_q;
		wired_d = wired_q;
		page_mask_d = page_mask_q;
		wide_d = wide_q;
		narrow_d = narrow_q;
		phase_d = phase_q;
		rd_c = '0;
		tgt_c = '0;
		jump_c = 1'b0;
		frch_c = 1'b0;
		st_c = mscc_pkg::ST_OK;
		tlb_wr.en = 1'b0;
		tlb_wr.addr = tlb_idx[mscc_pkg::TLB_IDX_W-1:0];
		tlb_wr.data.page_mask = page_mask_q;
		tlb_wr.data.entry_hi = wide_q[mscc_pkg::W_HI];
		tlb_wr.data.lo_even = wide_q[mscc_pkg::W_LO0];
		tlb_wr.data.lo_odd = wide_q[mscc_pkg::W_LO1];
		unique case (opcode_s1)
			mscc_pkg::OP_MFC0: begin
				priority if (reg_number_s1 == mscc_pkg::REG_INDEX) rd_c = 64'(index_q);
				else if (reg_number_s1 == mscc_pkg::REG_RANDOM) rd_c = 64'(random_q);
				else if (reg_number_s1 == mscc_pkg::REG_PAGEMASK) rd_c = 64'(page_mask_q);
				else if (reg_number_s1 == mscc_pkg::REG_WIRED) rd_c = 64'(wired_q);
				else if (ws.hit) rd_c = mscc_pkg::sext32(wide_q[ws.idx][31:0]);
				else if (ns.hit) rd_c = mscc_pkg::sext32(narrow_q[ns.idx]);
				else st_c = mscc_pkg::ST_BAD_REG;
			end
			mscc_pkg::OP_DMFC0: begin
				priority if (ws.hit) rd_c = wide_q[ws.idx];
				else if (ns.hit && ns.idx == mscc_pkg::N_COUNT)
					rd_c = 64'(narrow_q[mscc_pkg::N_COUNT]);
				else st_c = mscc_pkg::ST_BAD_REG;
			end
			mscc_pkg::OP_MTC0: begin
				priority if (reg_number_s1 == mscc_pkg::REG_INDEX) index_d = w32[5:0];
				else if (reg_number_s1 == mscc_pkg::REG_RANDOM) random_d = w32[5:0];
				else if (reg_number_s1 == mscc_pkg::REG_PAGEMASK)
					page_mask_d = w32 & mscc_pkg::PM_MASK;
				else if (reg_number_s1 == mscc_pkg::REG_WIRED) begin
					wired_d = w32[5:0];
					random_d = mscc_pkg::RANDOM_TOP;
				end else if (ws.hit) wide_d[ws.idx] = mscc_pkg::sext32(w32);
				else if (ns.hit && ns.idx == mscc_pkg::N_CMP) begin
					narrow_d[mscc_pkg::N_CMP] = w32;
					narrow_d[mscc_pkg::N_CAUSE][mscc_pkg::BIT_IP7] = 1'b0;
				end else if (ns.hit && ns.idx == mscc_pkg::N_SR) begin
					frch_c = w32[mscc_pkg::BIT_FR] ^ narrow_q[mscc_pkg::N_SR][mscc_pkg::BIT_FR];
					narrow_d[mscc_pkg::N_SR] = w32;
				end else if (ns.hit && ns.idx == mscc_pkg::N_CAUSE) begin
					narrow_d[mscc_pkg::N_CAUSE] =
						(narrow_q[mscc_pkg::N_CAUSE] & ~mscc_pkg::SOFT_IP) |
						(w32 & mscc_pkg::SOFT_IP);
				end else if (ns.hit) narrow_d[ns.idx] = w32;
				else st_c = mscc_pkg::ST_BAD_REG;
			end
			mscc_pkg::OP_DMTC0: begin
				if (ws.hit) wide_d[ws.idx] = write_data_s1;
				else st_c = mscc_pkg::ST_BAD_REG;
			end
			mscc_pkg::OP_TLBR: begin
				if ({1'b0, index_q} >= mscc_pkg::TLB_COUNT) begin
					st_c = mscc_pkg::ST_BAD_TLB;
				end else begin
					page_mask_d = tlb_rd.page_mask & mscc_pkg::PM_MASK;
					wide_d[mscc_pkg::W_HI] = tlb_rd.entry_hi;
					wide_d[mscc_pkg::W_LO0] = tlb_rd.lo_even;
					wide_d[mscc_pkg::W_LO1] = tlb_rd.lo_odd;
				end
			end
			mscc_pkg::OP_TLBWI: begin
				if ({1'b0, index_q} >= mscc_pkg::TLB_COUNT) st_c = mscc_pkg::ST_BAD_TLB;
				else tlb_wr.en = advance;
			end
			mscc_pkg::OP_TLBWR: begin
				random_d = (random_q == wired_q) ? mscc_pkg::RANDOM_TOP : random_q - 6'd1;
				if ({1'b0, random_q} >= mscc_pkg::TLB_COUNT) st_c = mscc_pkg::ST_BAD_TLB;
				else tlb_wr.en = advance;
			end
			mscc_pkg::OP_ERET: begin
				jump_c = 1'b1;
				if (narrow_q[mscc_pkg::N_SR][mscc_pkg::BIT_ERL]) begin
					tgt_c = wide_q[mscc_pkg::W_ERR];
					narrow_d[mscc_pkg::N_SR][mscc_pkg::BIT_ERL] = 1'b0;
				end else begin
					tgt_c = wide_q[mscc_pkg::W_EPC];
					narrow_d[mscc_pkg::N_SR][mscc_pkg::BIT_EXL] = 1'b0;
				end
			end
			mscc_pkg::OP_TICK: begin
				if (phase_q) begin
					narrow_d[mscc_pkg::N_COUNT] = count_inc;
					if (count_inc == narrow_q[mscc_pkg::N_CMP])
						narrow_d[mscc_pkg::N_CAUSE][mscc_pkg::BIT_IP7] = 1'b1;
				end
				phase_d = !phase_q;
			end
			default: begin
			end
		endcase
	end

	// Commit the register state when an item leaves the input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_q <= '0;
			random_q <= mscc_pkg::RANDOM_TOP;
			wired_q <= '0;
			page_mask_q <= '0;
			phase_q <= 1'b0;
			for (int i = 0; i < 8; i++) wide_q[i] <= '0;
			for (int i = 0; i < mscc_pkg::NARROW_N; i++) narrow_q[i] <= '0;
		end else if (advance) begin
			index_q <= index_d;
			random_q <= random_d;
			wired_q <= wired_d;
			page_mask_q <= page_mask_d;
			phase_q <= phase_d;
			wide_q <= wide_d;
			narrow_q <= narrow_d;
		end
	end

	// Result register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (advance) begin
			read_data <= rd_c;
			jump_taken <= jump_c;
			jump_target <= tgt_c;
			fr_changed <= frch_c;
			fr_mode <= narrow_d[mscc_pkg::N_SR][mscc_pkg::BIT_FR];
			timer_irq <= narrow_d[mscc_pkg::N_CAUSE][mscc_pkg::BIT_IP7];
			status <= st_c;
		end
	end

	`MSCC_ASSERT_IMPLY(a_stall_needs_item, clk, arst_n, in_stall, valid_s1 && out_valid)
	`MSCC_ASSERT_NEXT(a_advance_fills_result, clk, arst_n, advance, out_valid)
	`MSCC_ASSERT_IMPLY(a_eret_clean, clk, arst_n, out_valid && jump_taken,
		status == mscc_pkg::ST_OK && read_data == 64'd0)
endmodule
`default_nettype wire

// ----- tb/tb_mips_system_control_coprocessor.sv -----
// Self-checking testbench for the MIPS system control coprocessor: registers, TLB and timer.
`timescale 1ns / 1ps
`default_nettype none
module tb_mips_system_control_coprocessor;
	// Register numbers that the predictor treats specially.
	localparam logic [4:0] REG_ENTRYLO0 = 5'd2;
	localparam logic [4:0] REG_ENTRYLO1 = 5'd3;
	localparam logic [4:0] REG_COUNT = 5'd9;
	localparam logic [4:0] REG_ENTRYHI = 5'd10;
	localparam logic [4:0] REG_COMPARE = 5'd11;
	localparam logic [4:0] REG_STATUS = 5'd12;
	localparam logic [4:0] REG_CAUSE = 5'd13;
	localparam logic [4:0] REG_EPC = 5'd14;
	localparam logic [4:0] REG_ERROREPC = 5'd30;
	localparam int STALL_LIMIT = 3000;

	typedef struct {
		logic [63:0] read_data;
		logic jump_taken;
		logic [63:0] jump_target;
		logic fr_changed;
		logic fr_mode;
		logic timer_irq;
		logic [1:0] status;
	} cop0_result_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [3:0] opcode;
	logic [4:0] reg_number;
	logic [63:0] write_data;
	logic out_valid;
	logic out_stall;
	logic [63:0] read_data;
	logic jump_taken;
	logic [63:0] jump_target;
	logic fr_changed;
	logic fr_mode;
	logic timer_irq;
	logic [1:0] status;

	mips_system_control_coprocessor i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.reg_number(reg_number),
		.write_data(write_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.read_data(read_data),
		.jump_taken(jump_taken),
		.jump_target(jump_target),
		.fr_changed(fr_changed),
		.fr_mode(fr_mode),
		.timer_irq(timer_irq),
		.status(status)
	);

	// Predicted coprocessor state.
	logic [5:0] cp_index;
	logic [5:0] cp_random;
	logic [5:0] cp_wired;
	logic [31:0] cp_page_mask;
	logic [63:0] cp_wide [0:31];
	logic [31:0] cp_narrow [0:31];
	logic cp_tick_phase;
	logic [31:0] tlb_pm [0:63];
	logic [63:0] tlb_hi [0:63];
	logic [63:0] tlb_lo0 [0:63];
	logic [63:0] tlb_lo1 [0:63];
	bit tlb_written [0:63];

	cop0_result_t pending_results[$];
	int errors;
	int ops_sent;
	int results_seen;
	int idle_cycles;
	bit idle_on;
	int hold_len;
	int hold_id;

	// Clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [63:0] widen32(input logic [31:0] v);
		return {{32{v[31]}}, v};
	endfunction

	function automatic bit is_wide_reg(input logic [4:0] r);
		return r inside {5'd2, 5'd3, 5'd4, 5'd8, 5'd10, 5'd14, 5'd20, 5'd30};
	endfunction

	function automatic bit is_narrow_reg(input logic [4:0] r);
		return r inside {[5'd9 : 5'd9], [5'd11 : 5'd19], [5'd26 : 5'd29]};
	endfunction

	// Copies the staged EntryHi, EntryLo and PageMask into one TLB entry.
	task automatic store_tlb_entry(input logic [5:0] i);
		tlb_pm[i] = cp_page_mask;
		tlb_hi[i] = cp_wide[REG_ENTRYHI];
		tlb_lo0[i] = cp_wide[REG_ENTRYLO0];
		tlb_lo1[i] = cp_wide[REG_ENTRYLO1];
		tlb_written[i] = 1'b1;
	endtask

	// Applies one operation to the predicted state and queues the expected result.
	task automatic predict_cop0(input logic [3:0] op, input logic [4:0] rn, input logic [63:0] wd);
		cop0_result_t r;
		logic [31:0] w32;
		logic [5:0] i;
		r = '{default: '0};
		w32 = wd[31:0];
		case (op)
			mscc_pkg::OP_MFC0: begin
				if (rn == mscc_pkg::REG_INDEX) r.read_data = {58'd0, cp_index};
				else if (rn == mscc_pkg::REG_RANDOM) r.read_data = {58'd0, cp_random};
				else if (rn == mscc_pkg::REG_PAGEMASK) r.read_data = {32'd0, cp_page_mask};
				else if (rn == mscc_pkg::REG_WIRED) r.read_data = {58'd0, cp_wired};
				else if (is_wide_reg(rn)) r.read_data = widen32(cp_wide[rn][31:0]);
				else if (is_narrow_reg(rn)) r.read_data = widen32(cp_narrow[rn]);
				else r.status = mscc_pkg::ST_BAD_REG;
			end
			mscc_pkg::OP_DMFC0: begin
				if (is_wide_reg(rn)) r.read_data = cp_wide[rn];
				else if (rn == REG_COUNT) r.read_data = {32'd0, cp_narrow[REG_COUNT]};
				else r.status = mscc_pkg::ST_BAD_REG;
			end
			mscc_pkg::OP_MTC0: begin
				if (rn == mscc_pkg::REG_INDEX) cp_index = w32[5:0];
				else if (rn == mscc_pkg::REG_RANDOM) cp_random = w32[5:0];
				else if (rn == mscc_pkg::REG_PAGEMASK) cp_page_mask = w32 & mscc_pkg::PM_MASK;
				else if (rn == mscc_pkg::REG_WIRED) begin
					cp_wired = w32[5:0];
					cp_random = mscc_pkg::RANDOM_TOP;
				end else if (is_wide_reg(rn)) cp_wide[rn] = widen32(w32);
				else if (rn == REG_COMPARE) begin
					cp_narrow[REG_COMPARE] = w32;
					cp_narrow[REG_CAUSE][mscc_pkg::BIT_IP7] = 1'b0;
				end else if (rn == REG_STATUS) begin
					r.fr_changed = w32[mscc_pkg::BIT_FR] ^
						cp_narrow[REG_STATUS][mscc_pkg::BIT_FR];
					cp_narrow[REG_STATUS] = w32;
				end else if (rn == REG_CAUSE) begin
					cp_narrow[REG_CAUSE] = (cp_narrow[REG_CAUSE] & ~mscc_pkg::SOFT_IP) |
						(w32 & mscc_pkg::SOFT_IP);
				end else if (is_narrow_reg(rn)) cp_narrow[rn] = w32;
				else r.status = mscc_pkg::ST_BAD_REG;
			end
			mscc_pkg::OP_DMTC0: begin
				if (is_wide_reg(rn)) cp_wide[rn] = wd;
				else r.status = mscc_pkg::ST_BAD_REG;
			end
			mscc_pkg::OP_TLBR: begin
				i = cp_index;
				if (i >= mscc_pkg::TLB_ENTRIES) r.status = mscc_pkg::ST_BAD_TLB;
				else begin
					cp_page_mask = tlb_pm[i] & mscc_pkg::PM_MASK;
					cp_wide[REG_ENTRYHI] = tlb_hi[i];
					cp_wide[REG_ENTRYLO0] = tlb_lo0[i];
					cp_wide[REG_ENTRYLO1] = tlb_lo1[i];
				end
			end
			mscc_pkg::OP_TLBWI: begin
				i = cp_index;
				if (i >= mscc_pkg::TLB_ENTRIES) r.status = mscc_pkg::ST_BAD_TLB;
				else store_tlb_entry(i);
			end
			mscc_pkg::OP_TLBWR: begin
				i = cp_random;
				cp_random = (i == cp_wired) ? mscc_pkg::RANDOM_TOP : i - 6'd1;
				if (i >= mscc_pkg::TLB_ENTRIES) r.status = mscc_pkg::ST_BAD_TLB;
				else store_tlb_entry(i);
			end
			mscc_pkg::OP_ERET: begin
				r.jump_taken = 1'b1;
				if (cp_narrow[REG_STATUS][mscc_pkg::BIT_ERL]) begin
					r.jump_target = cp_wide[REG_ERROREPC];
					cp_narrow[REG_STATUS][mscc_pkg::BIT_ERL] = 1'b0;
				end else begin
					r.jump_target = cp_wide[REG_EPC];
					cp_narrow[REG_STATUS][mscc_pkg::BIT_EXL] = 1'b0;
				end
			end
			mscc_pkg::OP_TICK: begin
				if (cp_tick_phase) begin
					cp_narrow[REG_COUNT] = cp_narrow[REG_COUNT] + 32'd1;
					if (cp_narrow[REG_COUNT] == cp_narrow[REG_COMPARE])
						cp_narrow[REG_CAUSE][mscc_pkg::BIT_IP7] = 1'b1;
				end
				cp_tick_phase = ~cp_tick_phase;
			end
			default: begin
			end
		endcase
		r.fr_mode = cp_narrow[REG_STATUS][mscc_pkg::BIT_FR];
		r.timer_irq = cp_narrow[REG_CAUSE][mscc_pkg::BIT_IP7];
		pending_results.push_back(r);
	endtask

	// Offers one operation until its transfer is accepted; called at a rising edge.
	task automatic send_op(input logic [3:0] op, input logic [4:0] rn, input logic [63:0] wd);
		logic [3:0] o;
		bit stalled;
		int gap;
		o = op;
		// An entry never written may not be read back; write it instead.
		if (o == mscc_pkg::OP_TLBR && cp_index < mscc_pkg::TLB_ENTRIES &&
				!tlb_written[cp_index])
			o = mscc_pkg::OP_TLBWI;
		in_valid <= 1'b1;
		opcode <= o;
		reg_number <= rn;
		write_data <= wd;
		do begin
			@(negedge clk);
			stalled = in_stall;
			@(posedge clk);
		end while (stalled);
		predict_cop0(o, rn, wd);
		ops_sent++;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 10);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic logic [63:0] random_data();
		case ($urandom_range(0, 4))
			0: return '1;
			1: return '0;
			2: return {32'd0, $urandom};
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// Reports one field that differs from its prediction.
	function automatic void check_field(input string name, input logic [63:0] exp_v,
			input logic [63:0] got_v);
		if (got_v !== exp_v) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, got_v);
			errors++;
		end
	endfunction

	// Result checker and stall watchdog, sampled mid-cycle.
	always @(negedge clk) begin
		cop0_result_t e;
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
			else idle_cycles++;
			if (out_valid && !out_stall) begin
				results_seen++;
				if (pending_results.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual read_data %h",
						$time, read_data);
					errors++;
				end else begin
					e = pending_results.pop_front();
					check_field("read_data", e.read_data, read_data);
					check_field("jump_taken", e.jump_taken, jump_taken);
					check_field("jump_target", e.jump_target, jump_target);
					check_field("fr_changed", e.fr_changed, fr_changed);
					check_field("fr_mode", e.fr_mode, fr_mode);
					check_field("timer_irq", e.timer_irq, timer_irq);
					check_field("status", e.status, status);
				end
			end
			if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, idle_cycles);
				$display("Verification failed");
				$finish;
			end
		end
	end

	// Result receiver: random stall bursts, or a long hold when one is requested.
	always @(posedge clk or negedge arst_n) begin
		int stall_left;
		int hold_seen;
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
			hold_seen = 0;
		end else begin
			if (hold_id != hold_seen) begin
				hold_seen = hold_id;
				stall_left = hold_len;
			end else if (stall_left == 0 && idle_on && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 10);
			end
			out_stall <= (stall_left > 0);
			if (stall_left > 0) stall_left--;
		end
	end

	// Register moves: masks, sign extension, bad numbers, FR toggling, Cause and Wired.
	task automatic test_register_moves();
		send_op(mscc_pkg::OP_MTC0, mscc_pkg::REG_INDEX, '1);
		send_op(mscc_pkg::OP_MFC0, mscc_pkg::REG_INDEX, '0);
		send_op(mscc_pkg::OP_MTC0, mscc_pkg::REG_PAGEMASK, '1);
		send_op(mscc_pkg::OP_MFC0, mscc_pkg::REG_PAGEMASK, '0);
		send_op(mscc_pkg::OP_MTC0, REG_EPC, 64'h0000_0000_8000_0000);
		send_op(mscc_pkg::OP_DMFC0, REG_EPC, '0);
		send_op(mscc_pkg::OP_DMTC0, REG_ERROREPC, '1);
		send_op(mscc_pkg::OP_MFC0, REG_ERROREPC, '0);
		send_op(mscc_pkg::OP_MFC0, 5'd7, '0);
		send_op(mscc_pkg::OP_DMFC0, REG_STATUS, '0);
		send_op(mscc_pkg::OP_DMTC0, REG_CAUSE, '1);
		send_op(mscc_pkg::OP_MTC0, 5'd31, '1);
		send_op(mscc_pkg::OP_MTC0, REG_CAUSE, '1);
		send_op(mscc_pkg::OP_MTC0, REG_STATUS, 64'h0400_0000);
		send_op(mscc_pkg::OP_MTC0, REG_STATUS, '0);
		send_op(mscc_pkg::OP_MTC0, mscc_pkg::REG_WIRED, 64'd5);
		send_op(mscc_pkg::OP_MFC0, mscc_pkg::REG_RANDOM, '0);
		send_op(4'd15, 5'd0, '1);
	endtask

	// TLB: indexed write and read, bad index, random write from an out-of-range Random.
	task automatic test_tlb();
		send_op(mscc_pkg::OP_DMTC0, REG_ENTRYHI, 64'hdead_beef_0000_00a5);
		send_op(mscc_pkg::OP_MTC0, mscc_pkg::REG_INDEX, 64'd31);
		send_op(mscc_pkg::OP_TLBWI, 5'd0, '0);
		send_op(mscc_pkg::OP_TLBR, 5'd0, '0);
		send_op(mscc_pkg::OP_MTC0, mscc_pkg::REG_INDEX, 64'd40);
		send_op(mscc_pkg::OP_TLBWI, 5'd0, '0);
		send_op(mscc_pkg::OP_TLBR, 5'd0, '0);
		send_op(mscc_pkg::OP_MTC0, mscc_pkg::REG_RANDOM, 64'd63);
		send_op(mscc_pkg::OP_TLBWR, 5'd0, '0);
		send_op(mscc_pkg::OP_MTC0, mscc_pkg::REG_RANDOM, 64'd5);
		send_op(mscc_pkg::OP_TLBWR, 5'd0, '0);
		send_op(mscc_pkg::OP_TLBWR, 5'd0, '0);
	endtask

	// Timer: Count wraps onto Compare, then a Compare write clears the interrupt.
	task automatic test_timer();
		send_op(mscc_pkg::OP_MTC0, REG_COUNT, 64'hffff_ffff);
		send_op(mscc_pkg::OP_MTC0, REG_COMPARE, 64'd0);
		send_op(mscc_pkg::OP_TICK, 5'd0, '0);
		send_op(mscc_pkg::OP_TICK, 5'd0, '0);
		send_op(mscc_pkg::OP_DMFC0, REG_COUNT, '0);
		send_op(mscc_pkg::OP_MTC0, REG_COMPARE, 64'd7);
	endtask

	// Exception return through ErrorEPC, then through EPC.
	task automatic test_eret();
		send_op(mscc_pkg::OP_MTC0, REG_STATUS, 64'h6);
		send_op(mscc_pkg::OP_ERET, 5'd0, '0);
		send_op(mscc_pkg::OP_ERET, 5'd0, '0);
	endtask

	// Random traffic: mostly single operations, with TLB and timer sequences mixed in.
	task automatic test_random_ops(input int n);
		int k;
		int t;
		logic [4:0] rn;
		for (k = 0; k < n; k++) begin
			rn = $urandom_range(0, 31);
			case ($urandom_range(0, 19))
				0: begin
					send_op(mscc_pkg::OP_MTC0, mscc_pkg::REG_INDEX,
						{$urandom, 26'd0, 6'($urandom_range(0, 40))});
					send_op(mscc_pkg::OP_DMTC0, REG_ENTRYHI, random_data());
					send_op(mscc_pkg::OP_DMTC0, REG_ENTRYLO0, random_data());
					send_op(mscc_pkg::OP_MTC0, REG_ENTRYLO1, random_data());
					send_op(mscc_pkg::OP_MTC0, mscc_pkg::REG_PAGEMASK, random_data());
					send_op(mscc_pkg::OP_TLBWI, rn, random_data());
					send_op(mscc_pkg::OP_TLBR, rn, random_data());
					send_op(mscc_pkg::OP_DMFC0, REG_ENTRYLO0, random_data());
				end
				1: begin
					send_op(mscc_pkg::OP_MTC0, REG_COMPARE,
						{$urandom, cp_narrow[REG_COUNT] + 32'($urandom_range(0, 3))});
					for (t = 0; t < 8; t++) send_op(mscc_pkg::OP_TICK, rn, random_data());
					send_op(mscc_pkg::OP_MFC0, REG_CAUSE, random_data());
				end
				2, 3: send_op(mscc_pkg::OP_TICK, rn, random_data());
				4, 5, 6: send_op(mscc_pkg::OP_MFC0, rn, random_data());
				7, 8: send_op(mscc_pkg::OP_DMFC0, rn, random_data());
				9, 10, 11: send_op(mscc_pkg::OP_MTC0, rn, random_data());
				12, 13: send_op(mscc_pkg::OP_DMTC0, rn, random_data());
				14: send_op(mscc_pkg::OP_TLBR, rn, random_data());
				15: send_op(mscc_pkg::OP_TLBWI, rn, random_data());
				16: send_op(mscc_pkg::OP_TLBWR, rn, random_data());
				17: send_op(mscc_pkg::OP_ERET, rn, random_data());
				18: send_op(4'($urandom_range(9, 15)), rn, random_data());
				default: send_op(mscc_pkg::OP_MTC0,
					$urandom_range(0, 1) ? mscc_pkg::REG_WIRED : mscc_pkg::REG_RANDOM,
					{$urandom, 26'd0, 6'($urandom_range(0, 40))});
			endcase
		end
	endtask

	// Long receiver hold while operations keep coming, so the block backs up.
	task automatic test_backpressure();
		hold_len = 80;
		hold_id++;
		test_random_ops(40);
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		opcode = '0;
		reg_number = '0;
		write_data = '0;
		errors = 0;
		ops_sent = 0;
		results_seen = 0;
		idle_cycles = 0;
		idle_on = 1'b0;
		hold_len = 0;
		hold_id = 0;
		cp_index = '0;
		cp_random = mscc_pkg::RANDOM_TOP;
		cp_wired = '0;
		cp_page_mask = '0;
		cp_tick_phase = 1'b0;
		for (int k = 0; k < 64; k++) tlb_written[k] = 1'b0;
		for (int k = 0; k < 32; k++) begin
			cp_wide[k] = '0;
			cp_narrow[k] = '0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_on = 1'b1;
		test_register_moves();
		test_tlb();
		test_timer();
		test_eret();
		test_random_ops(700);
		test_backpressure();
		idle_on = 1'b0;
		test_random_ops(150);
		in_valid <= 1'b0;

		wait (pending_results.size() == 0);
		repeat (10) @(posedge clk);
		$display("Sent %0d coprocessor operations and checked %0d results,", ops_sent,
			results_seen);
		$display("covering register moves, TLB reads and writes, timer ticks and exception returns.");
		if (errors == 0 && pending_results.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end
endmodule
`default_nettype wire

// ----- files.f -----
+incdir+hdl
hdl/mscc_pkg.sv
hdl/mscc_tlb.sv
hdl/mips_system_control_coprocessor.sv
tb/tb_mips_system_control_coprocessor.sv
